// ===== rtl/inversion_pair_counter_defines.svh =====
// ---------------------------------------------------------------------------
// Inversion pair counter assertion macros
// Shared concurrent assertion forms, clocked on clk and held off by rst.
// ---------------------------------------------------------------------------
`ifndef INVERSION_PAIR_COUNTER_DEFINES_SVH
`define INVERSION_PAIR_COUNTER_DEFINES_SVH

// Condition must hold at every edge out of reset.
`define IPC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Trigger at one edge implies the check at the next edge.
`define IPC_ASSERT_NEXT(lbl, trig, chk, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (chk)) else $error(msg);

`endif

// ===== rtl/ipc_pkg.sv =====
// ---------------------------------------------------------------------------
// Inversion pair counter package
// Sizes and the request record that walks down the compare chain.
// ---------------------------------------------------------------------------
package ipc_pkg;

  localparam int MAX_LEN  = 256;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int TOTAL_W  = 15;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // One request in flight: its element, its place in the array, and the
  // number of greater stored elements seen so far.
  typedef struct packed {
    logic               vld;
    logic [VALUE_W-1:0] value;
    logic [POS_W-1:0]   pos;
    logic               ovf;
    logic               first;
    logic [POS_W-1:0]   cnt;
  } ipc_item_t;

endpackage

// ===== rtl/ipc_cell.sv =====
// ---------------------------------------------------------------------------
// Inversion pair counter cell
// Holds one array element; counts it against requests from later positions.
// ---------------------------------------------------------------------------
module ipc_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [ipc_pkg::POS_W-1:0] idx,
  input  ipc_pkg::ipc_item_t item_in,
  output ipc_pkg::ipc_item_t item_out
);
  import ipc_pkg::*;

  logic [VALUE_W-1:0] stored;
  logic               hit;
  ipc_item_t          item_next;

  // Only elements earlier in the same array sit below the request's position;
  // cells at or above it hold stale data and are skipped.
  assign hit = item_in.vld && !item_in.ovf && (item_in.pos > idx) &&
               ($signed(stored) > $signed(item_in.value));

  always_comb begin
    item_next     = item_in;
    item_next.cnt = item_in.cnt + POS_W'(hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.vld <= 1'b0;
    end else if (adv) begin
      item_out <= item_next;
    end
  end

  // Claim the element whose position matches this cell.
  always_ff @(posedge clk) begin
    if (adv && item_in.vld && !item_in.ovf && (item_in.pos == idx)) begin
      stored <= item_in.value;
    end
  end

endmodule

// ===== rtl/ipc_accum.sv =====
// ---------------------------------------------------------------------------
// Inversion pair counter accumulator
// Adds each request's count into the running total and holds the result.
// ---------------------------------------------------------------------------
`include "inversion_pair_counter_defines.svh"

module ipc_accum (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  ipc_pkg::ipc_item_t item_in,
  output logic               out_vld,
  output logic [ipc_pkg::TOTAL_W-1:0] total,
  output logic               overflow
);
  import ipc_pkg::*;

  logic [TOTAL_W-1:0] base;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_next;

  always_comb begin
    base = item_in.first ? '0 : total;
    sum  = {1'b0, base} + (TOTAL_W + 1)'(item_in.cnt);
    if (item_in.ovf) begin
      total_next = base;
    end else if (sum[TOTAL_W]) begin
      total_next = '1;
    end else begin
      total_next = sum[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
      total   <= '0;
    end else if (adv) begin
      out_vld <= item_in.vld;
      if (item_in.vld) begin
        total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_in.vld) begin
      overflow <= item_in.ovf;
    end
  end

  `IPC_ASSERT_NEXT(a_ovf_holds_total, adv && item_in.vld && item_in.ovf && !item_in.first, total == $past(total), "overflowed request changed the total")
  `IPC_ASSERT_NEXT(a_total_grows, adv && item_in.vld && !item_in.first, total >= $past(total), "running total decreased within an array")

endmodule

// ===== rtl/inversion_pair_counter.sv =====
// ---------------------------------------------------------------------------
// Inversion pair counter
// Counts inversion pairs of a streamed array in a chain of compare cells.
// ---------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tdata: value[31:0]; tuser: first
//  m_*       out        tdata: inversions[14:0], zero[15]; tuser: overflow
//
//  One request enters per cycle while the chain advances; its result reaches m_*
//  through MAX_LEN cell registers and then the accumulator register.
//  rst clears the position counter, the running total and all valid bits;
//  no clearing pass is needed, cells are only read below a request's position.
//  A result held on m_* with m_tready low freezes the whole chain, and
//  s_tready drops with it; while m_tvalid is low the chain keeps moving.
// ---------------------------------------------------------------------------
`include "inversion_pair_counter_defines.svh"

module inversion_pair_counter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [ipc_pkg::IN_TDATA_W-1:0]  s_tdata,   // value[31:0]
  input  logic        s_tuser,                        // first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [ipc_pkg::OUT_TDATA_W-1:0] m_tdata,   // inversions[14:0], zero[15]
  output logic        m_tuser                         // overflow
);
  import ipc_pkg::*;

  logic               adv;
  logic               s_acc;
  logic [POS_W-1:0]   count;
  logic [POS_W-1:0]   pos;
  logic               full;
  ipc_item_t          link [0:MAX_LEN];
  logic [TOTAL_W-1:0] total;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign s_acc    = s_tvalid && s_tready;

  assign pos  = s_tuser ? '0 : count;
  assign full = (pos == POS_W'(MAX_LEN));

  always_comb begin
    link[0].vld   = s_tvalid;
    link[0].value = s_tdata[VALUE_W-1:0];
    link[0].pos   = pos;
    link[0].ovf   = full;
    link[0].first = s_tuser;
    link[0].cnt   = '0;
  end

  // Position of the next element in the current array, held at capacity.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (s_acc && !full) begin
      count <= pos + POS_W'(1);
    end
  end

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    ipc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .idx      (POS_W'(i)),
      .item_in  (link[i]),
      .item_out (link[i+1])
    );
  end

  ipc_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .item_in  (link[MAX_LEN]),
    .out_vld  (m_tvalid),
    .total    (total),
    .overflow (m_tuser)
  );

  assign m_tdata = {{(OUT_TDATA_W - TOTAL_W){1'b0}}, total};

  `IPC_ASSERT_ALWAYS(a_count_cap, count <= POS_W'(MAX_LEN), "count passed capacity")
  `IPC_ASSERT_NEXT(a_first_restarts, s_acc && s_tuser, count == POS_W'(1), "count not restarted")

endmodule

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// Inversion pair counter testbench
// Streams signed arrays into the counter and checks every running total and
// overflow flag against a scoreboard that counts greater earlier elements.
// Both stream sides idle at random. One phase holds the output off long
// enough to stall the input.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RUN_LIMIT    = 400000;
  localparam int LONG_HOLD    = 600;
  localparam int RANDOM_ITEMS = 850;
  localparam int TOTAL_SAT    = 32767;

  typedef struct packed {
    logic [ipc_pkg::TOTAL_W-1:0] inversions;
    logic                        overflow;
  } pair_result_t;

  typedef enum int {MIX_NARROW, MIX_WIDE, MIX_EDGES} value_mix_t;

  logic                               clk;
  logic                               rst;
  logic                               s_tvalid;
  logic                               s_tready;
  logic [ipc_pkg::IN_TDATA_W-1:0]     s_tdata;   // value[31:0]
  logic                               s_tuser;   // first
  logic                               m_tvalid;
  logic                               m_tready;
  logic [ipc_pkg::OUT_TDATA_W-1:0]    m_tdata;   // inversions[14:0], zero[15]
  logic                               m_tuser;   // overflow

  // scoreboard copy of the array
  logic signed [ipc_pkg::VALUE_W-1:0] kept_vals [ipc_pkg::MAX_LEN];
  int                                 kept_cnt;
  int                                 pair_total;
  pair_result_t                       pending_totals [$];

  int mismatch_count;
  int cycle_count;
  int send_calm;
  int recv_calm;
  bit hold_request;

  inversion_pair_counter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Mostly random waits, with runs of back-to-back cycles now and then.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  task automatic send_elem(input logic signed [ipc_pkg::VALUE_W-1:0] v, input logic start);
    int           gap;
    int           greater;
    pair_result_t res;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    // request accepted: update the scoreboard array
    if (start) begin
      kept_cnt   = 0;
      pair_total = 0;
    end
    res.overflow = (kept_cnt >= ipc_pkg::MAX_LEN);
    if (!res.overflow) begin
      greater = 0;
      for (int i = 0; i < kept_cnt; i++) begin
        if (kept_vals[i] > v) greater++;
      end
      pair_total = (pair_total + greater > TOTAL_SAT) ? TOTAL_SAT : pair_total + greater;
      kept_vals[kept_cnt] = v;
      kept_cnt++;
    end
    res.inversions = pair_total[ipc_pkg::TOTAL_W-1:0];
    pending_totals.push_back(res);
  endtask

  task automatic test_no_start_flag();
    send_elem(32'sd5, 1'b0);
    send_elem(32'sd3, 1'b0);
    send_elem(32'sd3, 1'b0);
    send_elem(-32'sd1, 1'b0);
  endtask

  task automatic test_extremes();
    send_elem(32'h7FFF_FFFF, 1'b1);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0000_0000, 1'b0);
    send_elem(32'hFFFF_FFFF, 1'b0);
    send_elem(32'h7FFF_FFFF, 1'b0);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h0000_0001, 1'b0);
  endtask

  // equal elements never count
  task automatic test_ties();
    send_elem(32'sd7, 1'b1);
    send_elem(32'sd7, 1'b0);
    send_elem(32'sd7, 1'b0);
    send_elem(32'sd6, 1'b0);
    send_elem(32'sd8, 1'b0);
    send_elem(32'sd7, 1'b0);
  endtask

  task automatic test_back_to_back_starts();
    send_elem(32'sd3, 1'b1);
    send_elem(32'sd2, 1'b1);
    send_elem(32'sd1, 1'b1);
    send_elem(-32'sd5, 1'b1);
  endtask

  // Strictly descending full array gives the largest total, then the store
  // is full and further elements are dropped.
  task automatic test_full_store();
    for (int i = 0; i < ipc_pkg::MAX_LEN; i++) send_elem((127 - i) * 8000000, i == 0);
    send_elem(32'h8000_0000, 1'b0);
    send_elem(32'h7FFF_FFFF, 1'b0);
    send_elem($urandom(), 1'b0);
    send_elem($urandom(), 1'b0);
  endtask

  // Output held off while the input keeps offering back to back.
  task automatic test_output_stall();
    hold_request = 1'b1;
    send_calm    = 100;
    for (int i = 0; i < 100; i++) send_elem($urandom_range(0, 200) - 100, i == 0);
  endtask

  task automatic test_random_arrays();
    int                                 sent;
    int                                 len;
    int                                 pick;
    value_mix_t                         mix;
    logic                               start;
    logic signed [ipc_pkg::VALUE_W-1:0] v;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) len = $urandom_range(1, 40);
      else if (pick < 95) len = $urandom_range(41, 200);
      else len = $urandom_range(250, 270);
      pick = $urandom_range(0, 9);
      mix  = (pick < 4) ? MIX_NARROW : (pick < 8) ? MIX_WIDE : MIX_EDGES;
      for (int i = 0; i < len; i++) begin
        case (mix)
          MIX_NARROW: v = $urandom_range(0, 8) - 4;
          MIX_WIDE:   v = $urandom();
          default: begin
            case ($urandom_range(0, 4))
              0:       v = 32'h8000_0000;
              1:       v = 32'h7FFF_FFFF;
              2:       v = 32'h0000_0000;
              3:       v = 32'hFFFF_FFFF;
              default: v = $urandom();
            endcase
          end
        endcase
        // mostly clean arrays; now and then continue the last one or restart early
        if (i == 0) start = ($urandom_range(0, 19) != 0);
        else start = ($urandom_range(0, 32) == 0);
        send_elem(v, start);
        sent++;
      end
    end
  endtask

  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        idle_left    = LONG_HOLD;
        hold_request = 1'b0;
      end else if (m_tvalid && m_tready) begin
        idle_left = draw_wait(recv_calm);
      end else if (idle_left > 0) begin
        idle_left--;
      end
      m_tready <= (idle_left == 0);
    end
  end

  always @(posedge clk) begin : result_check
    pair_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_totals.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: inversions=%0d overflow=%0b",
                   m_tdata[ipc_pkg::TOTAL_W-1:0], m_tuser);
      end else begin
        want = pending_totals.pop_front();
        if (m_tdata[ipc_pkg::TOTAL_W-1:0] !== want.inversions || m_tdata[15] !== 1'b0 ||
            m_tuser !== want.overflow) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected inversions=%0d overflow=%0b, got tdata=%h overflow=%0b",
                     want.inversions, want.overflow, m_tdata, m_tuser);
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    s_tuser        <= 1'b0;
    kept_cnt       = 0;
    pair_total     = 0;
    mismatch_count = 0;
    send_calm      = 0;
    recv_calm      = 0;
    hold_request   = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_no_start_flag();
    test_extremes();
    test_ties();
    test_back_to_back_starts();
    test_full_store();
    test_output_stall();
    test_random_arrays();

    s_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    // let any stray result surface before judging
    repeat (ipc_pkg::MAX_LEN + 20) @(posedge clk);
    if (mismatch_count == 0 && pending_totals.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
